/* rtl/lcs_pkg.sv */
package lcs_pkg;

    localparam int DATA_W    = 16;
    localparam int FRAC_BITS = 12;
    localparam int LANE_W    = 16;

    typedef logic signed [DATA_W-1:0] data_t;

    // datapath operations
    typedef logic [3:0] op_t;
    localparam op_t OP_IDLE  = 4'd0;
    localparam op_t OP_LOAD  = 4'd1;
    localparam op_t OP_MUL   = 4'd2;
    localparam op_t OP_MAC   = 4'd3;
    localparam op_t OP_ADDB  = 4'd4;
    localparam op_t OP_ADDO  = 4'd5;
    localparam op_t OP_ACT   = 4'd6;
    localparam op_t OP_TANHC = 4'd7;
    localparam op_t OP_MOVEH = 4'd8;
    localparam op_t OP_EMIT  = 4'd9;

    // multiplier operand sources
    typedef logic [3:0] src_t;
    localparam src_t SRC_X    = 4'd0;
    localparam src_t SRC_H    = 4'd1;
    localparam src_t SRC_C    = 4'd2;
    localparam src_t SRC_WX   = 4'd3;
    localparam src_t SRC_WH   = 4'd4;
    localparam src_t SRC_F    = 4'd5;
    localparam src_t SRC_I    = 4'd6;
    localparam src_t SRC_O    = 4'd7;
    localparam src_t SRC_G    = 4'd8;
    localparam src_t SRC_T    = 4'd9;
    localparam src_t SRC_WOUT = 4'd10;

    typedef struct packed {
        op_t        op;
        src_t       sa;
        src_t       sb;
        logic [1:0] lane;
    } cmd_t;

    typedef struct packed {
        logic [63:0] input_weights;
        logic [63:0] recurrent_weights;
        logic [63:0] gate_biases;
        data_t       out_weight;
        data_t       out_bias;
    } cfg_t;

endpackage

/* rtl/lcs_in_if.sv */
interface lcs_in_if;
    logic                 valid;
    logic                 ready;
    lcs_pkg::data_t       sample;
    logic                 seq_start;

    modport source (output valid, output sample, output seq_start, input ready);
    modport sink   (input valid, input sample, input seq_start, output ready);
endinterface

/* rtl/lcs_out_if.sv */
interface lcs_out_if;
    logic                 valid;
    logic                 ready;
    lcs_pkg::data_t       hidden;
    lcs_pkg::data_t       cell_res;
    lcs_pkg::data_t       out_value;

    modport source (output valid, output hidden, output cell_res, output out_value,
                    input ready);
    modport sink   (input valid, input hidden, input cell_res, input out_value,
                    output ready);
endinterface

/* rtl/lstm_cell_scalar_step.sv */
// Scalar LSTM cell, one forward step per request.
// A request is taken only while idle; the next one is taken once the 24-step
// micro-program through the single shared multiplier and adder has run.
// A waiting result holds the final step only.
// Reset (rst_n, asynchronous, active low) clears cell and hidden state, the
// controller and all configuration registers (out_bias returns to -1.0).
module lstm_cell_scalar_step #(
    parameter int ACT_TABLE_DEPTH = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    lcs_in_if.sink       in_ch,
    lcs_out_if.source    out_ch,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    // register indexes, 8-byte spacing
    localparam logic [2:0] REG_IW   = 3'd0;
    localparam logic [2:0] REG_RW   = 3'd1;
    localparam logic [2:0] REG_GB   = 3'd2;
    localparam logic [2:0] REG_OW   = 3'd3;
    localparam logic [2:0] REG_OB   = 3'd4;

    lcs_pkg::cfg_t cfg_reg;
    lcs_pkg::cmd_t cmd;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // configuration registers; writes beyond the map are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.input_weights     <= '0;
            cfg_reg.recurrent_weights <= '0;
            cfg_reg.gate_biases       <= '0;
            cfg_reg.out_weight        <= '0;
            cfg_reg.out_bias          <= 16'shf000;
        end
        else if (wr_en)
        begin
            unique case (paddr[5:3])
                REG_IW:  cfg_reg.input_weights     <= pwdata;
                REG_RW:  cfg_reg.recurrent_weights <= pwdata;
                REG_GB:  cfg_reg.gate_biases       <= pwdata;
                REG_OW:  cfg_reg.out_weight        <= pwdata[15:0];
                REG_OB:  cfg_reg.out_bias          <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read back; the 16-bit registers come back zero-extended
    always_comb
    begin
        unique case (paddr[5:3])
            REG_IW:  prdata = cfg_reg.input_weights;
            REG_RW:  prdata = cfg_reg.recurrent_weights;
            REG_GB:  prdata = cfg_reg.gate_biases;
            REG_OW:  prdata = {48'd0, cfg_reg.out_weight};
            REG_OB:  prdata = {48'd0, cfg_reg.out_bias};
            default: prdata = '0;
        endcase
    end

    // sequencer: takes a request when idle, steps the datapath, hands over the result
    lcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    // shared multiplier, saturating adder, activation table and state
    lcs_dpath #(
        .ACT_TABLE_DEPTH (ACT_TABLE_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg_reg),
        .sample    (in_ch.sample),
        .seq_start (in_ch.seq_start),
        .hidden    (out_ch.hidden),
        .cell_res  (out_ch.cell_res),
        .out_value (out_ch.out_value)
    );

endmodule

/* rtl/lcs_ctrl.sv */
module lcs_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output lcs_pkg::cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;
    localparam int   NSTEPS  = 24;

    logic       state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    lcs_pkg::cmd_t rom_cmd;
    logic       stall;

    function automatic lcs_pkg::cmd_t mk(lcs_pkg::op_t op, lcs_pkg::src_t sa,
                                         lcs_pkg::src_t sb, logic [1:0] lane);
        lcs_pkg::cmd_t c;
        c.op = op;
        c.sa = sa;
        c.sb = sb;
        c.lane = lane;
        return c;
    endfunction

    // micro-program: four gates of four steps, then state update and output
    always_comb
    begin
        if (step_reg < 5'd16)
        begin
            unique case (step_reg[1:0])
                2'd0: rom_cmd = mk(lcs_pkg::OP_MUL, lcs_pkg::SRC_WX, lcs_pkg::SRC_X,
                                   step_reg[3:2]);
                2'd1: rom_cmd = mk(lcs_pkg::OP_MAC, lcs_pkg::SRC_WH, lcs_pkg::SRC_H,
                                   step_reg[3:2]);
                2'd2: rom_cmd = mk(lcs_pkg::OP_ADDB, lcs_pkg::SRC_X, lcs_pkg::SRC_X,
                                   step_reg[3:2]);
                default: rom_cmd = mk(lcs_pkg::OP_ACT, lcs_pkg::SRC_X, lcs_pkg::SRC_X,
                                      step_reg[3:2]);
            endcase
        end
        else
        begin
            unique case (step_reg)
                5'd16: rom_cmd = mk(lcs_pkg::OP_MUL, lcs_pkg::SRC_C, lcs_pkg::SRC_F, 2'd0);
                5'd17: rom_cmd = mk(lcs_pkg::OP_MAC, lcs_pkg::SRC_I, lcs_pkg::SRC_G, 2'd0);
                5'd18: rom_cmd = mk(lcs_pkg::OP_TANHC, lcs_pkg::SRC_X, lcs_pkg::SRC_X, 2'd0);
                5'd19: rom_cmd = mk(lcs_pkg::OP_MUL, lcs_pkg::SRC_O, lcs_pkg::SRC_T, 2'd0);
                5'd20: rom_cmd = mk(lcs_pkg::OP_MOVEH, lcs_pkg::SRC_X, lcs_pkg::SRC_X, 2'd0);
                5'd21: rom_cmd = mk(lcs_pkg::OP_MUL, lcs_pkg::SRC_H, lcs_pkg::SRC_WOUT, 2'd0);
                5'd22: rom_cmd = mk(lcs_pkg::OP_ADDO, lcs_pkg::SRC_X, lcs_pkg::SRC_X, 2'd0);
                default: rom_cmd = mk(lcs_pkg::OP_EMIT, lcs_pkg::SRC_X, lcs_pkg::SRC_X, 2'd0);
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    // hold the final step while the previous result is still waiting
    assign stall = (rom_cmd.op == lcs_pkg::OP_EMIT) && out_valid_reg && !out_ready;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = mk(lcs_pkg::OP_IDLE, lcs_pkg::SRC_X, lcs_pkg::SRC_X, 2'd0);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = mk(lcs_pkg::OP_LOAD, lcs_pkg::SRC_X, lcs_pkg::SRC_X, 2'd0);
                    state_next = ST_RUN;
                    step_next  = 5'd0;
                end
            end
            default:
            begin
                if (!stall)
                begin
                    cmd = rom_cmd;
                    if (step_reg == 5'(NSTEPS - 1))
                    begin
                        state_next     = ST_IDLE;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        step_next = step_reg + 5'd1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/lcs_dpath.sv */
module lcs_dpath #(
    parameter int ACT_TABLE_DEPTH = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  lcs_pkg::cmd_t  cmd,
    input  lcs_pkg::cfg_t  cfg,
    input  lcs_pkg::data_t sample,
    input  logic           seq_start,
    output lcs_pkg::data_t hidden,
    output lcs_pkg::data_t cell_res,
    output lcs_pkg::data_t out_value
);

    localparam int IDX_W = $clog2(ACT_TABLE_DEPTH);
    localparam int QX    = 28;

    typedef longint unsigned u64_t;

    // shift-subtract division, used only while building the table
    function automatic u64_t udiv(u64_t n, u64_t d);
        u64_t q;
        u64_t r;
        q = 0;
        r = 0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], n[i]};
            if (r >= d)
            begin
                r = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic u64_t exp_q(u64_t f);
        u64_t term;
        u64_t sum;
        term = u64_t'(1) << QX;
        sum  = term;
        for (int k = 1; k <= 20; k++)
        begin
            term = udiv((term * f) >> QX, u64_t'(k));
            sum  = sum + term;
        end
        return sum;
    endfunction

    // tanh(8k/depth) rounded to FRAC_BITS
    function automatic logic [12:0] tanh_entry(int k);
        u64_t one;
        u64_t em1;
        u64_t u;
        u64_t d;
        u64_t den;
        u64_t v;
        one = u64_t'(1) << QX;
        em1 = udiv(u64_t'(1) << (2 * QX), exp_q(one));
        u   = udiv(u64_t'(k) << (QX + 4), u64_t'(ACT_TABLE_DEPTH));
        d   = udiv(u64_t'(1) << (2 * QX), exp_q(u & (one - 1)));
        // the whole part of 2t runs up to fifteen
        for (int n = 0; n < 16; n++)
        begin
            if (u64_t'(n) < (u >> QX))
                d = (d * em1) >> QX;
        end
        if (d > one)
            d = one;
        den = one + d;
        v   = udiv(((one - d) << lcs_pkg::FRAC_BITS) + (den >> 1), den);
        return v[12:0];
    endfunction

    logic [12:0] act_tab [ACT_TABLE_DEPTH];

    for (genvar k = 0; k < ACT_TABLE_DEPTH; k++)
    begin : g_tab
        localparam logic [12:0] ENTRY = tanh_entry(k);
        assign act_tab[k] = ENTRY;
    end

    lcs_pkg::data_t x_reg, h_reg, c_reg, acc_reg, t_reg;
    lcs_pkg::data_t gate_reg [4];
    lcs_pkg::data_t hid_reg, cel_reg, val_reg;

    lcs_pkg::data_t opa, opb, bias;
    logic signed [31:0] prod;
    logic signed [19:0] prod_q;
    lcs_pkg::data_t fm;
    logic signed [16:0] sum_in, sum_add;
    lcs_pkg::data_t sum_sat;
    logic [16:0] mag;
    logic [31:0] scaled;
    logic [31:0] idx_full;
    logic [IDX_W-1:0] idx;
    logic [12:0] entry;
    logic signed [13:0] tval;
    logic signed [14:0] sig_sum;
    lcs_pkg::data_t act_val;
    logic use_sig;

    function automatic lcs_pkg::data_t lane_of(logic [63:0] w, logic [1:0] l);
        return lcs_pkg::data_t'(w[l*lcs_pkg::LANE_W +: lcs_pkg::LANE_W]);
    endfunction

    function automatic lcs_pkg::data_t sel(lcs_pkg::src_t s);
        lcs_pkg::data_t v;
        v = '0;
        case (s)
            lcs_pkg::SRC_X:    v = x_reg;
            lcs_pkg::SRC_H:    v = h_reg;
            lcs_pkg::SRC_C:    v = c_reg;
            lcs_pkg::SRC_WX:   v = lane_of(cfg.input_weights, cmd.lane);
            lcs_pkg::SRC_WH:   v = lane_of(cfg.recurrent_weights, cmd.lane);
            lcs_pkg::SRC_F:    v = gate_reg[0];
            lcs_pkg::SRC_I:    v = gate_reg[1];
            lcs_pkg::SRC_O:    v = gate_reg[2];
            lcs_pkg::SRC_G:    v = gate_reg[3];
            lcs_pkg::SRC_T:    v = t_reg;
            lcs_pkg::SRC_WOUT: v = cfg.out_weight;
            default:           v = '0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        opa = sel(cmd.sa);
        opb = sel(cmd.sb);
    end

    // product rounded toward minus infinity, then saturated
    assign prod   = 32'(opa) * 32'(opb);
    assign prod_q = prod[31:12];
    always_comb
    begin
        if (prod_q > 20'sd32767)
            fm = 16'sh7fff;
        else if (prod_q < -20'sd32768)
            fm = 16'sh8000;
        else
            fm = prod_q[15:0];
    end

    // saturating adder: acc + product or acc + bias
    always_comb
    begin
        bias = (cmd.op == lcs_pkg::OP_ADDO) ? cfg.out_bias
                                            : lane_of(cfg.gate_biases, cmd.lane);
        sum_in  = 17'(acc_reg);
        sum_add = (cmd.op == lcs_pkg::OP_MAC) ? 17'(fm) : 17'(bias);
        sum_in  = sum_in + sum_add;
        if (sum_in > 17'sd32767)
            sum_sat = 16'sh7fff;
        else if (sum_in < -17'sd32768)
            sum_sat = 16'sh8000;
        else
            sum_sat = sum_in[15:0];
    end

    // activation: sigmoid for the first three gates, tanh otherwise
    always_comb
    begin
        use_sig  = (cmd.op == lcs_pkg::OP_ACT) && (cmd.lane != 2'd3);
        mag      = acc_reg[15] ? 17'(-18'(acc_reg)) : 17'(acc_reg);
        scaled   = 32'(mag) * 32'(ACT_TABLE_DEPTH);
        idx_full = use_sig ? (scaled >> (lcs_pkg::FRAC_BITS + 4))
                           : (scaled >> (lcs_pkg::FRAC_BITS + 3));
        if (idx_full >= 32'(ACT_TABLE_DEPTH))
            idx = IDX_W'(ACT_TABLE_DEPTH - 1);
        else
            idx = idx_full[IDX_W-1:0];
        entry   = act_tab[idx];
        tval    = acc_reg[15] ? -14'(entry) : 14'(entry);
        sig_sum = 15'(1 << lcs_pkg::FRAC_BITS) + 15'(tval);
        act_val = use_sig ? 16'(sig_sum >>> 1) : 16'(tval);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg <= '0;
            c_reg <= '0;
        end
        else
        begin
            case (cmd.op)
                lcs_pkg::OP_LOAD:
                begin
                    if (seq_start)
                    begin
                        h_reg <= '0;
                        c_reg <= '0;
                    end
                end
                lcs_pkg::OP_TANHC: c_reg <= acc_reg;
                lcs_pkg::OP_MOVEH: h_reg <= acc_reg;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            lcs_pkg::OP_LOAD:  x_reg <= sample;
            lcs_pkg::OP_MUL:   acc_reg <= fm;
            lcs_pkg::OP_MAC,
            lcs_pkg::OP_ADDB,
            lcs_pkg::OP_ADDO:  acc_reg <= sum_sat;
            lcs_pkg::OP_ACT:   gate_reg[cmd.lane] <= act_val;
            lcs_pkg::OP_TANHC: t_reg <= act_val;
            lcs_pkg::OP_EMIT:
            begin
                hid_reg <= h_reg;
                cel_reg <= c_reg;
                val_reg <= acc_reg;
            end
            default: ;
        endcase
    end

    assign hidden    = hid_reg;
    assign cell_res  = cel_reg;
    assign out_value = val_reg;

endmodule
